@@ rtl/core/block_run_size_entropy_encoder_assert.svh @@
// assertion macros for the run/size entropy encoder
`ifndef BLOCK_RUN_SIZE_ENTROPY_ENCODER_ASSERT_SVH
`define BLOCK_RUN_SIZE_ENTROPY_ENCODER_ASSERT_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define BRSE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("brse assertion failed");

// condition must never be true outside reset
`define BRSE_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("brse forbidden condition seen");

`else

`define BRSE_ASSERT(label, clk, rst, prop)
`define BRSE_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ rtl/core/brse_pkg.sv @@
package brse_pkg;

   localparam int BLOCK_COEFFS = 64;
   localparam int POS_W        = (BLOCK_COEFFS > 2) ? $clog2(BLOCK_COEFFS) : 1;

   localparam int COEFF_W = 16;
   localparam int MAG_W   = 15;
   localparam int SIZE_W  = 4;
   localparam int RUN_W   = 4;
   localparam int BODY_W  = 23;
   localparam int BLEN_W  = 5;
   localparam int CODED_W = 38;
   localparam int COUNT_W = 6;
   localparam int TAIL_W  = 4;

   localparam logic [RUN_W-1:0]   ESCAPE_RUN  = 4'd15;
   localparam logic [7:0]         ESCAPE_CODE = 8'hF0;
   localparam logic [BLEN_W-1:0]  FIELD_LEN   = 5'd4;
   localparam logic [BLEN_W-1:0]  PAIR_LEN    = 5'd8;
   localparam logic [TAIL_W-1:0]  EOB_LEN     = 4'd8;

endpackage

@@ rtl/core/block_run_size_entropy_encoder.sv @@
// channel | ports                                  | direction
// --------+----------------------------------------+-----------
// request | req_valid req_ready req_coeff          | in
// result  | rsp_valid rsp_ready rsp_coded_bits     | out
//         | rsp_bit_count rsp_block_end            |
//
// one coefficient item per cycle while results are taken; an item passes through
// the input register, then the result register
// items that emit no bits (zero ac coefficient, no escape, not last) give no result
// synchronous active-high reset clears position, zero run, bit phase and valids
// a stalled result holds the output register; the input register still fills,
// so one more item is taken while a result waits

`include "block_run_size_entropy_encoder_assert.svh"

module block_run_size_entropy_encoder
   import brse_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COEFF_W-1:0]   req_coeff,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CODED_W-1:0]   rsp_coded_bits,
   output logic [COUNT_W-1:0]   rsp_bit_count,
   output logic                 rsp_block_end
);

   // block position, tracked at the input side
   logic [POS_W-1:0]    pos_ff, pos_in;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic [COEFF_W-1:0]  s1_coeff_ff;
   logic                s1_first_ff;
   logic                s1_last_ff;

   // coding state, updated as an item leaves the input register
   logic [RUN_W-1:0]    zero_run_ff, zero_run_in;
   logic [2:0]          bit_phase_ff, bit_phase_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODED_W-1:0]  rsp_bits_ff, rsp_bits_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_end_ff, rsp_end_in;

   logic                accept;
   logic                s1_move;
   logic                pos_last;

   // per-item coding signals
   logic                neg;
   logic [COEFF_W-1:0]  mag_full;
   logic [MAG_W-1:0]    mag;
   logic [SIZE_W-1:0]   size;
   logic [MAG_W-1:0]    vmask;
   logic [MAG_W-1:0]    vbits;
   logic                is_zero;
   logic                escape;
   logic [7:0]          hdr;
   logic [BLEN_W-1:0]   hlen;
   logic [BODY_W-1:0]   body;
   logic [BLEN_W-1:0]   blen;
   logic [2:0]          pad;
   logic [TAIL_W-1:0]   tail;
   logic [COUNT_W-1:0]  total_len;
   logic [CODED_W-1:0]  coded;

   // the input register moves on when the result register is free or being emptied
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   assign pos_last = (pos_ff == POS_W'(BLOCK_COEFFS - 1));

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = pos_last ? '0 : pos_ff + POS_W'(1);
      end
      s1_valid_in = accept || (s1_valid_ff && !s1_move);
   end

   // magnitude with the most negative pattern saturated to -32767
   assign neg      = s1_coeff_ff[COEFF_W-1];
   assign mag_full = neg ? (~s1_coeff_ff + COEFF_W'(1)) : s1_coeff_ff;
   assign mag      = (s1_coeff_ff == {1'b1, {(COEFF_W-1){1'b0}}}) ? {MAG_W{1'b1}}
                                                                 : mag_full[MAG_W-1:0];
   assign is_zero  = (mag == '0);

   // size = index of the highest set bit plus one
   always_comb begin
      size = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (mag[i]) begin
            size = SIZE_W'(i + 1);
         end
      end
   end

   // negative values: ones' complement of the magnitude over size bits
   assign vmask = MAG_W'((COEFF_W'(1) << size) - COEFF_W'(1));
   assign vbits = neg ? (~mag & vmask) : mag;

   assign escape = !s1_first_ff && is_zero && (zero_run_ff == ESCAPE_RUN);

   always_comb begin
      hdr  = '0;
      hlen = '0;
      body = '0;
      blen = '0;
      if (s1_first_ff) begin
         hdr  = {4'd0, size};
         hlen = FIELD_LEN;
      end else if (!is_zero) begin
         hdr  = {zero_run_ff, size};
         hlen = PAIR_LEN;
      end
      if (escape) begin
         body = BODY_W'(ESCAPE_CODE);
         blen = PAIR_LEN;
      end else if (s1_first_ff || !is_zero) begin
         body = (BODY_W'(hdr) << size) | BODY_W'(vbits);
         blen = hlen + BLEN_W'(size);
      end
   end

   // end of block: eight zero bits, then zero pad to the byte boundary
   always_comb begin
      pad  = 3'd0 - (bit_phase_ff + blen[2:0]);
      tail = s1_last_ff ? (EOB_LEN + TAIL_W'(pad)) : '0;
      coded     = CODED_W'(body) << tail;
      total_len = COUNT_W'(blen) + COUNT_W'(tail);
   end

   always_comb begin
      zero_run_in  = zero_run_ff;
      bit_phase_in = bit_phase_ff;
      if (s1_move) begin
         if (s1_first_ff || s1_last_ff || !is_zero) begin
            zero_run_in = '0;
         end else begin
            // fifteen plus one wraps to zero on the escape
            zero_run_in = zero_run_ff + RUN_W'(1);
         end
         bit_phase_in = bit_phase_ff + total_len[2:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_count_in = rsp_count_ff;
      rsp_end_in   = rsp_end_ff;
      if (s1_move) begin
         rsp_valid_in = (total_len != '0);
         if (total_len != '0) begin
            rsp_bits_in  = coded;
            rsp_count_in = total_len;
            rsp_end_in   = s1_last_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         zero_run_ff  <= '0;
         bit_phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         zero_run_ff  <= zero_run_in;
         bit_phase_ff <= bit_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_coeff_ff <= req_coeff;
         s1_first_ff <= (pos_ff == '0);
         s1_last_ff  <= pos_last;
      end
      rsp_bits_ff  <= rsp_bits_in;
      rsp_count_ff <= rsp_count_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coded_bits = rsp_bits_ff;
   assign rsp_bit_count  = rsp_count_ff;
   assign rsp_block_end  = rsp_end_ff;

   // a shown result always carries bits
   `BRSE_ASSERT_NEVER(a_count_zero, clock, reset, rsp_valid_ff && (rsp_count_ff == '0))
   // never more bits than the port holds
   `BRSE_ASSERT(a_count_max, clock, reset, rsp_valid_ff |-> (rsp_count_ff <= COUNT_W'(CODED_W)))
   // bits above the count are zero
   `BRSE_ASSERT(a_high_bits_zero, clock, reset, rsp_valid_ff |-> ((rsp_bits_ff >> rsp_count_ff) == '0))
   // a block end leaves the stream byte aligned
   `BRSE_ASSERT(a_block_aligned, clock, reset, (rsp_valid_ff && rsp_end_ff) |-> (bit_phase_ff == 3'd0))

endmodule

@@ tb/tb_block_run_size_entropy_encoder.sv @@
`timescale 1ns / 1ps

module tb_block_run_size_entropy_encoder;
   import brse_pkg::*;

   // no accepted item on either side for this many cycles ends the run
   localparam int STALL_LIMIT = 1000;
   // extra wait after the last expected result, to catch late extras
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [CODED_W-1:0] coded_bits;
      logic [COUNT_W-1:0] bit_count;
      logic               block_end;
   } chunk_type;

   // content shape of one random block
   typedef enum int {
      BLK_DENSE,
      BLK_SPARSE,
      BLK_SILENT,
      BLK_WIDE,
      BLK_RUNS
   } block_shape_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [COEFF_W-1:0]   req_coeff = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CODED_W-1:0]   rsp_coded_bits;
   logic [COUNT_W-1:0]   rsp_bit_count;
   logic                 rsp_block_end;

   // encoder shadow state
   int                   coeff_index = 0;
   int                   zero_count = 0;
   logic [2:0]           stream_phase = 3'd0;
   logic [63:0]          chunk_acc;
   int                   chunk_len;

   chunk_type            pending_chunks[$];
   int                   mismatch_count = 0;
   int                   quiet_cycles = 0;
   // when set neither side idles
   bit                   no_idle = 1'b0;

   block_run_size_entropy_encoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_coeff      (req_coeff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_coded_bits (rsp_coded_bits),
      .rsp_bit_count  (rsp_bit_count),
      .rsp_block_end  (rsp_block_end)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      // keep the log short on a systematic fault, but count every one
      if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // shift n bits into the chunk being built, msb first
   function automatic void append_bits(input logic [31:0] value, input int n);
      if (n == 0) return;
      chunk_acc = (chunk_acc << n) | (64'(value) & ((64'd1 << n) - 64'd1));
      chunk_len += n;
   endfunction

   // advance the shadow encoder by one coefficient; returns 1 when bits come out
   function automatic bit encode_coeff(input logic [COEFF_W-1:0] raw, output chunk_type chunk);
      int v;
      int mag;
      int bits;
      int pad;
      int sz;
      bit last;
      v = $signed(raw);
      // most negative pattern is clamped so the size fits in four bits
      if (v < -32767) v = -32767;
      mag = (v < 0) ? -v : v;
      sz = 0;
      while (mag != 0) begin
         sz++;
         mag = mag >> 1;
      end
      // negatives in ones' complement style over size bits
      bits = (v > 0) ? v : v + (1 << sz) - 1;
      chunk_acc = '0;
      chunk_len = 0;
      last = (coeff_index + 1 >= BLOCK_COEFFS);

      if (coeff_index == 0) begin
         // dc: size then value bits, no run field
         append_bits(sz, SIZE_W);
         append_bits(bits, sz);
         zero_count = 0;
      end else if (v == 0) begin
         zero_count++;
         // sixteenth zero in a row gives the run-15/size-0 escape
         if (zero_count == 16) begin
            append_bits(ESCAPE_RUN, RUN_W);
            append_bits(0, SIZE_W);
            zero_count = 0;
         end
      end else begin
         append_bits(zero_count & 15, RUN_W);
         append_bits(sz, SIZE_W);
         append_bits(bits, sz);
         zero_count = 0;
      end

      if (last) begin
         // end-of-block code, then pad the stream to a byte boundary
         append_bits(0, RUN_W);
         append_bits(0, SIZE_W);
         pad = (8 - ((stream_phase + chunk_len) & 7)) & 7;
         append_bits(0, pad);
         coeff_index = 0;
         zero_count = 0;
      end else begin
         coeff_index++;
      end

      stream_phase = stream_phase + chunk_len[2:0];
      chunk.coded_bits = chunk_acc[CODED_W-1:0];
      chunk.bit_count  = chunk_len[COUNT_W-1:0];
      chunk.block_end  = last;
      return (chunk_len != 0);
   endfunction

   // offer one coefficient item, with random idle cycles ahead of it
   task automatic send_coeff(input logic [COEFF_W-1:0] coeff);
      chunk_type chunk;
      while (!no_idle && ($urandom_range(0, 99) < 34)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coeff <= coeff;
      // ready is stable by the falling edge; if high, the next rising edge takes it
      do @(negedge clock); while (!req_ready);
      if (encode_coeff(coeff, chunk)) pending_chunks.push_back(chunk);
      @(posedge clock);
   endtask

   // random coefficient; zero_pct sets how often it is zero
   function automatic logic [COEFF_W-1:0] random_coeff(input int zero_pct);
      int sz;
      int mag;
      int pick;
      if ($urandom_range(0, 99) < zero_pct) return '0;
      pick = $urandom_range(0, 9);
      if (pick == 0) return COEFF_W'($urandom);
      if (pick == 1) begin
         case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8001;
            2: return 16'h8000;
            3: return 16'h0001;
            default: return 16'hFFFF;
         endcase
      end
      sz = $urandom_range(1, 15);
      mag = $urandom_range((1 << (sz - 1)), (1 << sz) - 1);
      return ($urandom_range(0, 1) != 0) ? COEFF_W'(-mag) : COEFF_W'(mag);
   endfunction

   // first block: dc at the top, then ac extremes and the clamped pattern
   task automatic test_ac_extremes();
      send_coeff(16'h7FFF);
      send_coeff(16'h8000);
      send_coeff(16'h8001);
      send_coeff(16'h7FFF);
      send_coeff(16'h0001);
      send_coeff(16'hFFFF);
      send_coeff(16'h4000);
      send_coeff(16'hC000);
   endtask

   // fifteen silent zeros, the escape on the sixteenth, then a coded value
   task automatic test_zero_run_escape();
      repeat (16) send_coeff('0);
      send_coeff(16'h0005);
   endtask

   // count coefficients of shaped random content; the last coefficient of a block closes it
   task automatic test_random_blocks(input int count);
      block_shape_type shape;
      int run_gap;
      int zero_pct;
      logic [COEFF_W-1:0] coeff;
      shape = BLK_DENSE;
      run_gap = 16;
      for (int n = 0; n < count; n++) begin
         // one quiet stretch where neither side idles
         no_idle = (n >= 400) && (n < 560);
         if (coeff_index == 0) begin
            shape = block_shape_type'($urandom_range(0, 4));
            run_gap = $urandom_range(14, 18);
         end
         case (shape)
            BLK_DENSE:  zero_pct = 20;
            BLK_SPARSE: zero_pct = 85;
            BLK_SILENT: zero_pct = 100;
            BLK_WIDE:   zero_pct = 0;
            default:    zero_pct = 100;
         endcase
         if (coeff_index == 0) begin
            coeff = random_coeff(10);
         end else if (shape == BLK_RUNS) begin
            // long zero runs broken at a chosen spacing around the escape length
            coeff = ((coeff_index % run_gap) == 0) ? random_coeff(0) : '0;
         end else begin
            coeff = random_coeff(zero_pct);
         end
         send_coeff(coeff);
      end
      no_idle = 1'b0;
   endtask

   // result side idles at random except in the quiet stretch
   always @(posedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 34);
   end

   // result check: the handshake seen at the falling edge completes at the next rising edge
   always @(negedge clock) begin
      chunk_type exp_chunk;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chunks.size() == 0) begin
            report_mismatch($sformatf("result item with none expected: bits %h count %0d",
                                      rsp_coded_bits, rsp_bit_count));
         end else begin
            exp_chunk = pending_chunks.pop_front();
            if (rsp_coded_bits !== exp_chunk.coded_bits)
               report_mismatch($sformatf("coded_bits %h, expected %h",
                                         rsp_coded_bits, exp_chunk.coded_bits));
            if (rsp_bit_count !== exp_chunk.bit_count)
               report_mismatch($sformatf("bit_count %0d, expected %0d",
                                         rsp_bit_count, exp_chunk.bit_count));
            if (rsp_block_end !== exp_chunk.block_end)
               report_mismatch($sformatf("block_end %b, expected %b",
                                         rsp_block_end, exp_chunk.block_end));
         end
      end
   end

   // watchdog on cycles with no accepted item on either channel
   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_ac_extremes();
      test_zero_run_escape();
      test_random_blocks(1025);

      req_valid <= 1'b0;
      // drain every expected result, then allow for late extras
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_chunks.size() != 0)
         report_mismatch($sformatf("%0d expected results never came", pending_chunks.size()));

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
